// ----- design/gyro_quaternion_integrator_macros.svh -----
// Assertion macros shared by the gyro quaternion integrator.
`ifndef GYRO_QUATERNION_INTEGRATOR_MACROS_SVH
`define GYRO_QUATERNION_INTEGRATOR_MACROS_SVH

// Condition implies expression in the same cycle.
`define GQI_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Condition implies expression in the next cycle.
`define GQI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/gqi_pkg.sv -----
// Package with types, constants and tables of the gyro quaternion integrator.
`default_nettype none
package gqi_pkg;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_HALF_MUL, ST_HALF_WB, ST_MAG_MUL, ST_MAG_WB, ST_NORM_SHIFT,
      ST_SQ_MUL, ST_SQ_WB, ST_SQRT, ST_MOD, ST_FOLD, ST_CORDIC, ST_CS_END,
      ST_DIV, ST_V_MUL, ST_V_WB, ST_MAC, ST_DONE
   } state_type;

   // One term of a gravity sum: negate flag and the two quaternion indexes.
   typedef struct packed {
      logic       neg;
      logic [1:0] a;
      logic [1:0] b;
   } grav_term_type;

   localparam logic [31:0]        TICK_RESET   = 32'd4295;
   localparam int                 ATAN_ENTRIES = 30;
   localparam logic [32:0]        MOD_TWO_PI   = 33'd6746518852;
   localparam logic signed [35:0] Z_PI         = 36'sd3373259426;
   localparam logic signed [35:0] Z_HALF_PI    = 36'sd1686629713;
   localparam logic signed [35:0] Z_TWO_PI     = 36'sd6746518852;
   localparam logic signed [33:0] INV_GAIN     = 34'sd652032875;
   localparam logic signed [33:0] CS_ONE       = 34'sd1073741824;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      logic signed [35:0] r;
      case (i)
         5'd0:  r = 36'sd843314857;
         5'd1:  r = 36'sd497837829;
         5'd2:  r = 36'sd263043837;
         5'd3:  r = 36'sd133525159;
         5'd4:  r = 36'sd67021687;
         5'd5:  r = 36'sd33543516;
         5'd6:  r = 36'sd16775851;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194283;
         5'd9:  r = 36'sd2097149;
         default: r = 36'sd1 <<< (5'd30 - i);
      endcase
      return r;
   endfunction

   // Negated terms of each Hamilton product component, one bit per term.
   function automatic logic [3:0] ham_neg(input logic [1:0] j);
      logic [3:0] r;
      case (j)
         2'd0:    r = 4'b1110;
         2'd1:    r = 4'b1000;
         2'd2:    r = 4'b0010;
         default: r = 4'b0100;
      endcase
      return r;
   endfunction

   // Gravity terms; pairs of equal terms give the factor of two.
   function automatic grav_term_type grav_term(input logic [1:0] g, input logic [1:0] t);
      grav_term_type r;
      case (g)
         2'd0:    r = (t < 2'd2) ? grav_term_type'{1'b0, 2'd1, 2'd3}
                                 : grav_term_type'{1'b1, 2'd0, 2'd2};
         2'd1:    r = (t < 2'd2) ? grav_term_type'{1'b0, 2'd2, 2'd3}
                                 : grav_term_type'{1'b0, 2'd0, 2'd1};
         default: r = '{(t == 2'd1) || (t == 2'd2), t, t};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/gqi_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none
module gqi_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] mul_a,
   input  wire logic signed [32:0] mul_b,
   output logic signed [65:0]      mul_p
);

   logic signed [65:0] p_ff;
   logic signed [65:0] p_in;

   // Full product of two 33-bit operands.
   always_comb begin
      p_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign mul_p = p_ff;

endmodule
`default_nettype wire

// ----- design/gyro_quaternion_integrator.sv -----
// Top level of the gyro quaternion integrator: sequencer, datapath and stream ports.
`include "gyro_quaternion_integrator_macros.svh"
`default_nettype none
// Integrates gyro rates into a Q2.30 attitude quaternion and predicts gravity in the body
// frame. The first word after reset only primes the previous sample; each later word gives
// one result word built from the previous rates and the interval between the two stamps.
// One shared 33x33 multiplier, a restoring square root (32 steps), a mod-2pi reduction
// (one doubling per normalizing shift), a CORDIC (min(CORDIC_STEPS,30) steps) and three
// restoring divisions (31 steps each) run one after another. A zero rotation skips the
// reduction, the CORDIC and the divisions. A priming word leaves the sequencer idle;
// req_tready is low while any other word is worked on. A finished result waits in the
// output register while the next word is taken in; a result still waiting there holds
// the sequencer in its last state.
module gyro_quaternion_integrator #(
   parameter int QUAT_FRAC_BITS = 30,
   parameter int CORDIC_STEPS   = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // stamp_ticks, rate_x, rate_y, rate_z, 32 bits each, from the lowest bit up.
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // half_interval, att_w, att_x, att_y, att_z, grav_x, grav_y, grav_z, from the lowest bit.
   output logic [255:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_wen,
   input  wire logic [31:0]  csr_wdata
);

   localparam int NSTEPS = (CORDIC_STEPS < gqi_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : gqi_pkg::ATAN_ENTRIES;
   localparam logic [5:0] LAST_STEP = 6'(NSTEPS - 1);
   localparam int CS_SHIFT = 30 - QUAT_FRAC_BITS;
   localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< QUAT_FRAC_BITS;
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (QUAT_FRAC_BITS - 1);

   gqi_pkg::state_type state_ff, state_in;

   logic               have_prev_ff, have_prev_in;
   logic [31:0]        tick_ff, tick_in;
   logic [31:0]        last_stamp_ff, last_stamp_in;
   logic [31:0]        last_rate_ff [3];
   logic [31:0]        last_rate_in [3];
   logic signed [31:0] att_ff [4];
   logic signed [31:0] att_in [4];
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        diff_ff, diff_in;
   logic [31:0]        rmag_ff [3];
   logic [31:0]        rmag_in [3];
   logic [2:0]         negv_ff, negv_in;
   logic [31:0]        half_ff, half_in;
   logic [61:0]        mag_ff [3];
   logic [61:0]        mag_in [3];
   logic [61:0]        sh_ff [3];
   logic [61:0]        sh_in [3];
   logic [4:0]         s_ff, s_in;
   logic [1:0]         idx_ff, idx_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        norm_ff, norm_in;
   logic [32:0]        mrem_ff, mrem_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [35:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] e_ff [4];
   logic signed [31:0] e_in [4];
   logic signed [31:0] sn_ff, sn_in;
   logic [30:0]        quo_ff, quo_in;
   logic [2:0]         j_ff, j_in;
   logic [2:0]         t_ff, t_in;
   logic               sgn_ff, sgn_in;
   logic signed [31:0] qn_ff [4];
   logic signed [31:0] qn_in [4];
   logic signed [31:0] g_ff [3];
   logic signed [31:0] g_in [3];

   logic [31:0]        out_half_ff, out_half_in;
   logic signed [31:0] out_att_ff [4];
   logic signed [31:0] out_att_in [4];
   logic signed [31:0] out_grav_ff [3];
   logic signed [31:0] out_grav_in [3];

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   gqi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // Sequencer and datapath next values.
   always_comb begin
      logic [63:0]        bitv;
      logic [63:0]        trial;
      logic [63:0]        res_nx;
      logic [33:0]        mr2;
      logic signed [35:0] zf;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [63:0] sum;
      logic signed [63:0] rnd;
      logic signed [31:0] rq;
      logic signed [31:0] vv;
      logic [31:0]        r;
      logic [3:0]         hn;
      gqi_pkg::grav_term_type gt;

      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      tick_in       = csr_wen ? csr_wdata : tick_ff;
      last_stamp_in = last_stamp_ff;
      last_rate_in  = last_rate_ff;
      att_in        = att_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      diff_in       = diff_ff;
      rmag_in       = rmag_ff;
      negv_in       = negv_ff;
      half_in       = half_ff;
      mag_in        = mag_ff;
      sh_in         = sh_ff;
      s_in          = s_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      res_in        = res_ff;
      norm_in       = norm_ff;
      mrem_in       = mrem_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      neg_in        = neg_ff;
      e_in          = e_ff;
      sn_in         = sn_ff;
      quo_in        = quo_ff;
      j_in          = j_ff;
      t_in          = t_ff;
      sgn_in        = sgn_ff;
      qn_in         = qn_ff;
      g_in          = g_ff;
      out_half_in   = out_half_ff;
      out_att_in    = out_att_ff;
      out_grav_in   = out_grav_ff;
      mul_a         = '0;
      mul_b         = '0;
      req_tready    = 1'b0;
      bitv          = '0;
      trial         = '0;
      res_nx        = '0;
      mr2           = '0;
      zf            = '0;
      xs            = '0;
      ys            = '0;
      sum           = '0;
      rnd           = '0;
      rq            = '0;
      vv            = '0;
      r             = '0;
      hn            = '0;
      gt            = '0;

      case (state_ff)
         gqi_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // Work on the previous rates; the new word becomes the previous sample.
               diff_in = req_tdata[31:0] - last_stamp_ff;
               for (int i = 0; i < 3; i++) begin
                  r          = last_rate_ff[i];
                  negv_in[i] = r[31];
                  rmag_in[i] = r[31] ? (~r + 32'd1) : r;
               end
               last_stamp_in   = req_tdata[31:0];
               last_rate_in[0] = req_tdata[63:32];
               last_rate_in[1] = req_tdata[95:64];
               last_rate_in[2] = req_tdata[127:96];
               have_prev_in    = 1'b1;
               if (have_prev_ff) begin
                  state_in = gqi_pkg::ST_HALF_MUL;
               end
            end
         end
         gqi_pkg::ST_HALF_MUL: begin
            mul_a    = {1'b0, diff_ff};
            mul_b    = {1'b0, tick_ff};
            state_in = gqi_pkg::ST_HALF_WB;
         end
         gqi_pkg::ST_HALF_WB: begin
            // Half interval in Q16.16, saturating.
            half_in  = (mul_p[63:49] != '0) ? 32'hFFFF_FFFF : mul_p[48:17];
            idx_in   = 2'd0;
            state_in = gqi_pkg::ST_MAG_MUL;
         end
         gqi_pkg::ST_MAG_MUL: begin
            mul_a    = {1'b0, half_ff};
            mul_b    = {1'b0, rmag_ff[idx_ff]};
            state_in = gqi_pkg::ST_MAG_WB;
         end
         gqi_pkg::ST_MAG_WB: begin
            mag_in[idx_ff] = mul_p[63:2];
            sh_in[idx_ff]  = mul_p[63:2];
            if (idx_ff == 2'd2) begin
               s_in     = '0;
               state_in = gqi_pkg::ST_NORM_SHIFT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = gqi_pkg::ST_MAG_MUL;
            end
         end
         gqi_pkg::ST_NORM_SHIFT: begin
            // Shift all magnitudes right until each fits in 31 bits.
            if ((sh_ff[0][61:31] != '0) || (sh_ff[1][61:31] != '0) ||
                (sh_ff[2][61:31] != '0)) begin
               for (int i = 0; i < 3; i++) begin
                  sh_in[i] = sh_ff[i] >> 1;
               end
               s_in = s_ff + 5'd1;
            end else begin
               idx_in   = 2'd0;
               acc_in   = '0;
               state_in = gqi_pkg::ST_SQ_MUL;
            end
         end
         gqi_pkg::ST_SQ_MUL: begin
            mul_a    = {2'b00, sh_ff[idx_ff][30:0]};
            mul_b    = {2'b00, sh_ff[idx_ff][30:0]};
            state_in = gqi_pkg::ST_SQ_WB;
         end
         gqi_pkg::ST_SQ_WB: begin
            sum    = acc_ff + mul_p[63:0];
            acc_in = sum;
            if (idx_ff == 2'd2) begin
               rem_in   = sum;
               res_in   = '0;
               cnt_in   = '0;
               state_in = gqi_pkg::ST_SQRT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = gqi_pkg::ST_SQ_MUL;
            end
         end
         gqi_pkg::ST_SQRT: begin
            // One restoring square root step, two radicand bits at a time.
            bitv  = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
            trial = res_ff + bitv;
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_nx = (res_ff >> 1) + bitv;
            end else begin
               res_nx = res_ff >> 1;
            end
            res_in = res_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               norm_in = res_nx << s_ff;
               if (res_nx == '0) begin
                  // Zero rotation gives the identity.
                  e_in[0]  = 32'(ONE_Q);
                  e_in[1]  = '0;
                  e_in[2]  = '0;
                  e_in[3]  = '0;
                  j_in     = '0;
                  t_in     = '0;
                  acc_in   = '0;
                  state_in = gqi_pkg::ST_MAC;
               end else begin
                  // The root itself is below 2pi; the shift is undone modulo 2pi.
                  mrem_in  = res_nx[32:0];
                  cnt_in   = {1'b0, s_ff};
                  state_in = gqi_pkg::ST_MOD;
               end
            end
         end
         gqi_pkg::ST_MOD: begin
            // Double the angle modulo 2pi once per normalizing shift.
            if (cnt_ff == '0) begin
               state_in = gqi_pkg::ST_FOLD;
            end else begin
               mr2 = {mrem_ff, 1'b0};
               if (mr2 >= {1'b0, gqi_pkg::MOD_TWO_PI}) begin
                  mr2 = mr2 - {1'b0, gqi_pkg::MOD_TWO_PI};
               end
               mrem_in = mr2[32:0];
               cnt_in  = cnt_ff - 6'd1;
            end
         end
         gqi_pkg::ST_FOLD: begin
            // Fold the angle into [-pi/2, pi/2], remembering a sign flip.
            zf     = {3'b000, mrem_ff};
            neg_in = 1'b0;
            if (zf > gqi_pkg::Z_PI) begin
               zf = zf - gqi_pkg::Z_TWO_PI;
            end
            if (zf > gqi_pkg::Z_HALF_PI) begin
               zf     = zf - gqi_pkg::Z_PI;
               neg_in = 1'b1;
            end else if (zf < -gqi_pkg::Z_HALF_PI) begin
               zf     = zf + gqi_pkg::Z_PI;
               neg_in = 1'b1;
            end
            z_in     = zf;
            x_in     = gqi_pkg::INV_GAIN;
            y_in     = '0;
            cnt_in   = '0;
            state_in = gqi_pkg::ST_CORDIC;
         end
         gqi_pkg::ST_CORDIC: begin
            xs = x_ff >>> cnt_ff[4:0];
            ys = y_ff >>> cnt_ff[4:0];
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - gqi_pkg::atan_q30(cnt_ff[4:0]);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + gqi_pkg::atan_q30(cnt_ff[4:0]);
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = gqi_pkg::ST_CS_END;
            end
         end
         gqi_pkg::ST_CS_END: begin
            // Undo the fold, clamp to one and scale to the quaternion format.
            xs = neg_ff ? -x_ff : x_ff;
            ys = neg_ff ? -y_ff : y_ff;
            if (xs > gqi_pkg::CS_ONE) xs = gqi_pkg::CS_ONE;
            if (xs < -gqi_pkg::CS_ONE) xs = -gqi_pkg::CS_ONE;
            if (ys > gqi_pkg::CS_ONE) ys = gqi_pkg::CS_ONE;
            if (ys < -gqi_pkg::CS_ONE) ys = -gqi_pkg::CS_ONE;
            e_in[0]  = 32'(xs >>> CS_SHIFT);
            sn_in    = 32'(ys >>> CS_SHIFT);
            idx_in   = 2'd0;
            rem_in   = (64'(mag_ff[0]) > norm_ff) ? norm_ff : 64'(mag_ff[0]);
            quo_in   = '0;
            cnt_in   = 6'd30;
            state_in = gqi_pkg::ST_DIV;
         end
         gqi_pkg::ST_DIV: begin
            // One restoring division step of min(|v_i|,|v|) / |v|.
            if (rem_ff >= norm_ff) begin
               rem_in = (rem_ff - norm_ff) << 1;
               quo_in = {quo_ff[29:0], 1'b1};
            end else begin
               rem_in = rem_ff << 1;
               quo_in = {quo_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = gqi_pkg::ST_V_MUL;
            end
         end
         gqi_pkg::ST_V_MUL: begin
            mul_a    = 33'(sn_ff);
            mul_b    = {2'b00, quo_ff};
            state_in = gqi_pkg::ST_V_WB;
         end
         gqi_pkg::ST_V_WB: begin
            vv = mul_p[61:30];
            e_in[idx_ff + 2'd1] = negv_ff[idx_ff] ? -vv : vv;
            if (idx_ff == 2'd2) begin
               j_in     = '0;
               t_in     = '0;
               acc_in   = '0;
               state_in = gqi_pkg::ST_MAC;
            end else begin
               idx_in   = idx_ff + 2'd1;
               rem_in   = (64'(mag_ff[idx_ff + 2'd1]) > norm_ff) ?
                          norm_ff : 64'(mag_ff[idx_ff + 2'd1]);
               quo_in   = '0;
               cnt_in   = 6'd30;
               state_in = gqi_pkg::ST_DIV;
            end
         end
         gqi_pkg::ST_MAC: begin
            // Issue one product per cycle and add the one issued the cycle before.
            if (t_ff < 3'd4) begin
               if (j_ff < 3'd4) begin
                  mul_a  = 33'(att_ff[t_ff[1:0]]);
                  mul_b  = 33'(e_ff[j_ff[1:0] ^ t_ff[1:0]]);
                  hn     = gqi_pkg::ham_neg(j_ff[1:0]);
                  sgn_in = hn[t_ff[1:0]];
               end else begin
                  gt     = gqi_pkg::grav_term(j_ff[1:0], t_ff[1:0]);
                  mul_a  = 33'(qn_ff[gt.a]);
                  mul_b  = 33'(qn_ff[gt.b]);
                  sgn_in = gt.neg;
               end
            end
            sum = acc_ff;
            if (t_ff != '0) begin
               sum = sgn_ff ? (acc_ff - mul_p[63:0]) : (acc_ff + mul_p[63:0]);
            end
            acc_in = sum;
            t_in   = t_ff + 3'd1;
            if (t_ff == 3'd4) begin
               // Round half up, then saturate to plus or minus one.
               rnd = (sum + HALF_LSB) >>> QUAT_FRAC_BITS;
               if (rnd > ONE_Q) rnd = ONE_Q;
               if (rnd < -ONE_Q) rnd = -ONE_Q;
               rq = 32'(rnd);
               if (j_ff < 3'd4) begin
                  qn_in[j_ff[1:0]] = rq;
               end else begin
                  g_in[j_ff[1:0]] = rq;
               end
               t_in   = '0;
               acc_in = '0;
               j_in   = j_ff + 3'd1;
               if (j_ff == 3'd6) begin
                  state_in = gqi_pkg::ST_DONE;
               end
            end
         end
         gqi_pkg::ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               out_half_in  = half_ff;
               out_att_in   = qn_ff;
               out_grav_in  = g_ff;
               att_in       = qn_ff;
               rsp_valid_in = 1'b1;
               state_in     = gqi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gqi_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gqi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and kept state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         tick_ff       <= gqi_pkg::TICK_RESET;
         last_stamp_ff <= '0;
         last_rate_ff  <= '{default: '0};
         att_ff        <= '{32'(ONE_Q), 32'sd0, 32'sd0, 32'sd0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         tick_ff       <= tick_in;
         last_stamp_ff <= last_stamp_in;
         last_rate_ff  <= last_rate_in;
         att_ff        <= att_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers of the datapath.
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      rmag_ff     <= rmag_in;
      negv_ff     <= negv_in;
      half_ff     <= half_in;
      mag_ff      <= mag_in;
      sh_ff       <= sh_in;
      s_ff        <= s_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      norm_ff     <= norm_in;
      mrem_ff     <= mrem_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      neg_ff      <= neg_in;
      e_ff        <= e_in;
      sn_ff       <= sn_in;
      quo_ff      <= quo_in;
      j_ff        <= j_in;
      t_ff        <= t_in;
      sgn_ff      <= sgn_in;
      qn_ff       <= qn_in;
      g_ff        <= g_in;
      out_half_ff <= out_half_in;
      out_att_ff  <= out_att_in;
      out_grav_ff <= out_grav_in;
   end

   // Result word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_grav_ff[2], out_grav_ff[1], out_grav_ff[0],
                        out_att_ff[3], out_att_ff[2], out_att_ff[1], out_att_ff[0],
                        out_half_ff};

   // A word that follows the first one starts the sequencer.
   `GQI_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready && have_prev_ff, !req_tready,
      "sequencer did not start on a word")
   // The priming word gives no result and leaves the block ready.
   `GQI_ASSERT_NEXT(a_prime_no_result, clock, reset,
      req_tvalid && req_tready && !have_prev_ff, req_tready,
      "priming word started the sequencer")
   // The quaternion scalar part stays within plus or minus one.
   `GQI_ASSERT_NOW(a_att_w_range, clock, reset, rsp_valid_ff,
      (64'(out_att_ff[0]) <= ONE_Q) && (64'(out_att_ff[0]) >= -ONE_Q),
      "attitude scalar part out of range")

endmodule
`default_nettype wire

// ----- sim/gyro_quaternion_integrator_tb.sv -----
// Self-checking testbench of the gyro quaternion integrator with its own attitude predictor.
`default_nettype none
module gyro_quaternion_integrator_tb;

   localparam int FRAC         = 30;
   localparam int ROT_STEPS    = 24;
   localparam int SETTLE       = 600;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_ITEMS = 1130;

   // One result word, unpacked.
   typedef struct {
      logic [31:0]        half_interval;
      logic signed [31:0] att[4];
      logic signed [31:0] grav[3];
   } attitude_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [127:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_wen = 1'b0;
   logic [31:0]  csr_wdata = '0;

   gyro_quaternion_integrator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state.
   logic [31:0]       tick_sec;
   bit                primed;
   logic [31:0]       prev_stamp;
   logic [31:0]       prev_rate[3];
   longint            att_q[4];
   attitude_word_type pending_words[$];
   int                error_count;
   int                words_sent;
   int                words_checked;
   int                burst_left;
   longint unsigned   cycle_count;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // floor(2^30 * num / den) by restoring division.
   function automatic longint share_q30(input longint unsigned num, input longint unsigned den);
      longint unsigned rem;
      longint q;
      rem = num;
      q = 0;
      for (int b = 30; b >= 0; b--) begin
         if (rem >= den) begin
            rem -= den;
            q |= longint'(1) << b;
         end
         rem <<= 1;
      end
      return q;
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > (longint'(1) << 30)) return longint'(1) << 30;
      if (v < -(longint'(1) << 30)) return -(longint'(1) << 30);
      return v;
   endfunction

   function automatic longint round_frac(input longint sum);
      return clamp_unit((sum + (longint'(1) << (FRAC - 1))) >>> FRAC);
   endfunction

   // Rotation-mode CORDIC over an angle in [0, 2pi), folded to [-pi/2, pi/2].
   task automatic rotate_unit(input longint theta, output longint c, output longint s);
      longint x, y, z, dx, dy;
      bit flip;
      x = gqi_pkg::INV_GAIN;
      y = 0;
      z = theta;
      flip = 0;
      if (z > gqi_pkg::Z_PI) z -= gqi_pkg::Z_TWO_PI;
      if (z > gqi_pkg::Z_HALF_PI) begin
         z -= gqi_pkg::Z_PI;
         flip = 1;
      end else if (z < -gqi_pkg::Z_HALF_PI) begin
         z += gqi_pkg::Z_PI;
         flip = 1;
      end
      for (int i = 0; i < ROT_STEPS && i < gqi_pkg::ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= gqi_pkg::atan_q30(i[4:0]);
         end else begin
            x += dx; y -= dy; z += gqi_pkg::atan_q30(i[4:0]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
   endtask

   // Advances the attitude by one accepted sample and queues the word it yields.
   task automatic integrate_sample(input logic [127:0] data);
      longint unsigned half, mag[3], maxm, sum, norm, m;
      logic [31:0] r, rm, dstamp;
      bit negv[3];
      longint e[4], q[4], w, x, y, z, c, sn, v;
      int sh;
      attitude_word_type word;
      if (!primed) begin
         primed = 1;
      end else begin
         // The stamp difference wraps at 32 bits.
         dstamp = data[31:0] - prev_stamp;
         half = (64'(dstamp) * 64'(tick_sec)) >> 17;
         if (half > 64'hFFFF_FFFF) half = 64'hFFFF_FFFF;
         maxm = 0;
         for (int i = 0; i < 3; i++) begin
            r = prev_rate[i];
            negv[i] = r[31];
            rm = negv[i] ? (~r + 32'd1) : r;
            mag[i] = (half * longint'(rm)) >> 2;
            if (mag[i] > maxm) maxm = mag[i];
         end
         sh = 0;
         while ((maxm >> sh) >= 64'h8000_0000) sh++;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            m = mag[i] >> sh;
            sum += m * m;
         end
         norm = int_sqrt(sum) << sh;
         if (norm == 0) begin
            e[0] = longint'(1) << FRAC;
            e[1] = 0; e[2] = 0; e[3] = 0;
         end else begin
            rotate_unit(longint'(norm % gqi_pkg::MOD_TWO_PI), c, sn);
            e[0] = c >>> (30 - FRAC);
            sn = sn >>> (30 - FRAC);
            for (int i = 0; i < 3; i++) begin
               v = (sn * share_q30((mag[i] > norm) ? norm : mag[i], norm)) >>> 30;
               e[1 + i] = negv[i] ? -v : v;
            end
         end
         w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
         q[0] = round_frac(w * e[0] - x * e[1] - y * e[2] - z * e[3]);
         q[1] = round_frac(w * e[1] + x * e[0] + y * e[3] - z * e[2]);
         q[2] = round_frac(w * e[2] - x * e[3] + y * e[0] + z * e[1]);
         q[3] = round_frac(w * e[3] + x * e[2] - y * e[1] + z * e[0]);
         att_q = q;
         w = q[0]; x = q[1]; y = q[2]; z = q[3];
         word.half_interval = half[31:0];
         for (int i = 0; i < 4; i++) word.att[i] = q[i][31:0];
         word.grav[0] = 32'(round_frac(2 * (x * z - w * y)));
         word.grav[1] = 32'(round_frac(2 * (y * z + w * x)));
         word.grav[2] = 32'(round_frac(w * w - x * x - y * y + z * z));
         pending_words = {pending_words, word};
      end
      prev_stamp = data[31:0];
      prev_rate[0] = data[63:32];
      prev_rate[1] = data[95:64];
      prev_rate[2] = data[127:96];
   endtask

   // Sends one sample word; valid stays high within a burst and drops for random gaps.
   task automatic send_sample(input logic [31:0] stamp, input logic [31:0] rx,
                              input logic [31:0] ry, input logic [31:0] rz);
      int gap;
      req_tdata  <= {rz, ry, rx, stamp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      integrate_sample({rz, ry, rx, stamp});
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 40);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Waits for all results, lets the block settle, then writes the tick scale.
   task automatic set_tick(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      tick_sec = value;
      csr_wen  <= 1'b0;
   endtask

   function automatic logic [31:0] random_rate();
      logic [31:0] r;
      case ($urandom_range(0, 4))
         0: r = $urandom_range(0, 32'h0004_0000);
         1: r = -$urandom_range(0, 32'h0004_0000);
         2: r = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         3: r = $urandom;
         default: r = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] random_step();
      logic [31:0] d;
      case ($urandom_range(0, 5))
         0: d = 0;
         1: d = $urandom_range(1, 16);
         2, 3: d = $urandom_range(1, 20000);
         4: d = $urandom_range(1, 2000000);
         default: d = $urandom;
      endcase
      return d;
   endfunction

   // Extremes of stamps and rates, first sample, zero rotation, repeat and wrap of stamps.
   task automatic test_directed();
      send_sample(32'h0000_0000, 32'h0, 32'h0, 32'h0);
      send_sample(32'h0000_1000, 32'h0001_0000, 32'h0, 32'h0);
      send_sample(32'h0000_1000, 32'h0, 32'h0001_0000, 32'h0);
      send_sample(32'h0000_2000, 32'h0, 32'h0, 32'hFFFF_0000);
      send_sample(32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'h0000_0010, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_sample(32'h0001_0010, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
      send_sample(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'h1234_5678, 32'hEDCB_A988, 32'h5555_5555);
      send_sample(32'h8000_0000, 32'hAAAA_AAAA, 32'h0, 32'h0);
   endtask

   // Tick scale at its extremes: a huge scale saturates the interval and wraps the angle.
   task automatic test_tick_extremes();
      set_tick(32'hFFFF_FFFF);
      send_sample(32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0);
      send_sample(32'h0000_0003, 32'h0, 32'h0, 32'h0);
      set_tick(32'd1);
      send_sample(32'h0000_0004, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0004, 32'h0, 32'h0, 32'h0);
      send_sample(32'h8000_0005, 32'h0, 32'h0, 32'h0);
   endtask

   // Random samples over several tick scales, the reset value among them.
   task automatic test_random();
      logic [31:0] ticks[5];
      logic [31:0] stamp;
      ticks[0] = gqi_pkg::TICK_RESET;
      ticks[1] = $urandom_range(1, 100000);
      ticks[2] = $urandom;
      ticks[3] = 32'd1;
      ticks[4] = 32'hFFFF_FFFF;
      stamp = $urandom;
      for (int phase = 0; phase < 5; phase++) begin
         set_tick(ticks[phase]);
         for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
            stamp += random_step();
            send_sample(stamp, random_rate(), random_rate(), random_rate());
         end
      end
   endtask

   // Receiver stalls in four rotating modes (always, random, rarely, mostly ready); result check against the queue.
   always @(posedge clock) begin
      attitude_word_type want;
      logic [31:0] got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      case ((cycle_count >> 6) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) != 0);
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (cycle_count[2:0] != 3'd0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("result word with no expectation pending");
            error_count++;
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_tdata[31:0] !== want.half_interval) begin
               $error("half_interval: expected %h, got %h", want.half_interval,
                      rsp_tdata[31:0]);
               error_count++;
            end
            for (int i = 0; i < 7; i++) begin
               got = rsp_tdata[32 * (i + 1) +: 32];
               if (i < 4 && got !== want.att[i]) begin
                  $error("att[%0d] (w,x,y,z): expected %h, got %h", i, want.att[i], got);
                  error_count++;
               end else if (i >= 4 && got !== want.grav[i - 4]) begin
                  $error("grav[%0d] (x,y,z): expected %h, got %h", i - 4, want.grav[i - 4],
                         got);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      tick_sec      = gqi_pkg::TICK_RESET;
      primed        = 0;
      prev_stamp    = '0;
      prev_rate     = '{default: '0};
      att_q         = '{longint'(1) << FRAC, 0, 0, 0};
      error_count   = 0;
      words_sent    = 0;
      words_checked = 0;
      burst_left    = 0;
      cycle_count   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tick_extremes();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d samples and checked %0d attitude words over several tick scales,",
               words_sent, words_checked);
      $display("with stamp wrap, repeated stamps, zero and extreme rates, bursty input.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
